// ===== rtl/bamf_pkg.sv =====
// Shared types and reset constants for the advertising-data manufacturer filter.
`timescale 1ns / 1ps

package bamf_pkg;

  // Walk phase, one-hot
  typedef enum logic [4:0] {
    PH_LEN     = 5'b00001,
    PH_TYPE    = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PREFIX_WORD = 2'd0,
    REG_WANTED_TYPE = 2'd1,
    REG_TAG_VALUE   = 2'd2,
    REG_FLAG_MASK   = 2'd3
  } reg_idx_t;

  localparam logic [31:0] PREFIX_WORD_RST = 32'h2D01_0300;
  localparam logic [7:0]  WANTED_TYPE_RST = 8'hFF;
  localparam logic [7:0]  TAG_VALUE_RST   = 8'h22;
  localparam logic [7:0]  FLAG_MASK_RST   = 8'h42;

  localparam int unsigned PREFIX_BYTES = 4;

  typedef struct packed {
    logic [31:0] prefix_word;
    logic [7:0]  wanted_type;
    logic [7:0]  tag_value;
    logic [7:0]  flag_mask;
  } cfg_t;

  typedef struct packed {
    logic match_found;
    logic pairing_on;
  } res_t;

endpackage

// ===== rtl/bamf_walker.sv =====
// Length/type structure walker: per-byte state update and verdict.
`timescale 1ns / 1ps

module bamf_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  input  bamf_pkg::cfg_t     cfg,
  output bamf_pkg::res_t     res
);

  bamf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [2:0] payload_index_r, payload_index_nxt;
  logic       tag_pending_r, tag_pending_nxt;
  logic       scan_done_r, scan_done_nxt;
  logic       pairing_flag_r, pairing_flag_nxt;
  logic       verdict_r, verdict_nxt;

  logic [7:0] left_dec;
  logic [7:0] want_byte;

  assign left_dec  = bytes_left_r - 8'd1;
  // prefix bytes go out MSB first
  assign want_byte = cfg.prefix_word[{~payload_index_r[1:0], 3'b000} +: 8];

  always_comb begin
    phase_nxt         = phase_r;
    bytes_left_nxt    = bytes_left_r;
    payload_index_nxt = payload_index_r;
    tag_pending_nxt   = tag_pending_r;
    scan_done_nxt     = scan_done_r;
    pairing_flag_nxt  = pairing_flag_r;
    verdict_nxt       = verdict_r;
    case (phase_r)
      bamf_pkg::PH_LEN: begin
        if (data_byte == 8'd0) begin
          verdict_nxt = 1'b0;
          phase_nxt   = bamf_pkg::PH_DONE;
        end else begin
          bytes_left_nxt = data_byte;
          phase_nxt      = bamf_pkg::PH_TYPE;
        end
      end
      bamf_pkg::PH_TYPE: begin
        bytes_left_nxt = left_dec;
        if (data_byte == cfg.wanted_type) begin
          if (left_dec < 8'(bamf_pkg::PREFIX_BYTES)) begin
            verdict_nxt = 1'b0;
            phase_nxt   = bamf_pkg::PH_DONE;
          end else begin
            payload_index_nxt = 3'd0;
            tag_pending_nxt   = 1'b0;
            scan_done_nxt     = 1'b0;
            pairing_flag_nxt  = 1'b0;
            phase_nxt         = bamf_pkg::PH_PAYLOAD;
          end
        end else if (left_dec == 8'd0) begin
          phase_nxt = bamf_pkg::PH_LEN;
        end else begin
          phase_nxt = bamf_pkg::PH_SKIP;
        end
      end
      bamf_pkg::PH_SKIP: begin
        bytes_left_nxt = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = bamf_pkg::PH_LEN;
        end
      end
      bamf_pkg::PH_PAYLOAD: begin
        bytes_left_nxt = left_dec;
        if (!payload_index_r[2] && (data_byte != want_byte)) begin
          // prefix mismatch decides at once
          payload_index_nxt = payload_index_r + 3'd1;
          verdict_nxt       = 1'b0;
          phase_nxt         = bamf_pkg::PH_DONE;
        end else begin
          if (!payload_index_r[2]) begin
            payload_index_nxt = payload_index_r + 3'd1;
          end else if (!scan_done_r) begin
            if (tag_pending_r) begin
              pairing_flag_nxt = (data_byte & cfg.flag_mask) == cfg.flag_mask;
              tag_pending_nxt  = 1'b0;
              scan_done_nxt    = 1'b1;
            end else if (data_byte == cfg.tag_value) begin
              tag_pending_nxt = 1'b1;
            end
          end
          if (left_dec == 8'd0) begin
            verdict_nxt = 1'b1;
            phase_nxt   = bamf_pkg::PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res.match_found = verdict_nxt;
  assign res.pairing_on  = verdict_nxt & pairing_flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      phase_r         <= bamf_pkg::PH_LEN;
      bytes_left_r    <= 8'd0;
      payload_index_r <= 3'd0;
      tag_pending_r   <= 1'b0;
      scan_done_r     <= 1'b0;
      pairing_flag_r  <= 1'b0;
      verdict_r       <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_index_r <= payload_index_nxt;
      tag_pending_r   <= tag_pending_nxt;
      scan_done_r     <= scan_done_nxt;
      pairing_flag_r  <= pairing_flag_nxt;
      verdict_r       <= verdict_nxt;
    end
  end

endmodule

// ===== rtl/ble_adv_manufacturer_filter_top.sv =====
// Top level: advertisement byte filter with input stage, config regs and result register.
// Usage:
//  - Input channel (in_valid/in_stall): one advertisement byte per transfer on
//    in_data_byte, with in_is_last high on the final byte.
//  - Result channel (out_valid/out_stall): one transfer per advertisement,
//    out_match_found and out_pairing_on, issued for the final byte only.
//  - Config channel (cfg_valid/cfg_ready): cfg_index selects prefix word,
//    wanted type, tag value or flag mask; cfg_data carries the value. Write
//    only while no advertisement is in flight. cfg_ready is always high.
//  - Throughput: one byte per cycle unless a final byte waits for a free
//    result slot; the walk update from the input register to the state/result
//    registers is combinational, and the verdict goes into the result register.
//  - Receiver stall: the result register holds; a final byte waits in the
//    input stage and in_stall rises, other bytes keep flowing.
//  - Reset (rst_n low, synchronous): walk state cleared, registers return to
//    their defaults, both pipeline stages empty.
`timescale 1ns / 1ps

module ble_adv_manufacturer_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match_found,
  output logic        out_pairing_on,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bamf_pkg::cfg_t cfg_r;
  bamf_pkg::res_t res;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  logic       out_match_r;
  logic       out_pairing_r;

  logic out_free;
  logic s1_go;
  logic in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_word <= bamf_pkg::PREFIX_WORD_RST;
      cfg_r.wanted_type <= bamf_pkg::WANTED_TYPE_RST;
      cfg_r.tag_value   <= bamf_pkg::TAG_VALUE_RST;
      cfg_r.flag_mask   <= bamf_pkg::FLAG_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (bamf_pkg::reg_idx_t'(cfg_index))
        bamf_pkg::REG_PREFIX_WORD: cfg_r.prefix_word <= cfg_data;
        bamf_pkg::REG_WANTED_TYPE: cfg_r.wanted_type <= cfg_data[7:0];
        bamf_pkg::REG_TAG_VALUE:   cfg_r.tag_value   <= cfg_data[7:0];
        bamf_pkg::REG_FLAG_MASK:   cfg_r.flag_mask   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Only a final byte needs a free result slot to move on
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_is_last;
    end
  end

  bamf_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_byte_r),
    .is_last   (s1_last_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_match_r   <= res.match_found;
      out_pairing_r <= res.pairing_on;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_found = out_match_r;
  assign out_pairing_on  = out_pairing_r;

endmodule

// ===== test/adv_filter_checker.sv =====
// Checker for the advertisement filter: mirrors the registers, predicts each verdict, compares.
`timescale 1ns / 1ps

module adv_filter_checker
  import bamf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_match_found,
  input  logic        out_pairing_on,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  cfg_t       regs;
  phase_t     walk_phase;
  logic [7:0] remaining;
  logic [2:0] pay_idx;
  logic       prefix_good;
  logic       tag_seen;
  logic       flags_taken;
  logic       pair_flag;
  logic       settled;
  logic       verdict_match;

  res_t verdicts_due[$];
  int   fail_count = 0;

  task automatic clear_walk();
    walk_phase    = PH_LEN;
    remaining     = 8'd0;
    pay_idx       = 3'd0;
    prefix_good   = 1'b1;
    tag_seen      = 1'b0;
    flags_taken   = 1'b0;
    pair_flag     = 1'b0;
    settled       = 1'b0;
    verdict_match = 1'b0;
  endtask

  task automatic settle(input logic v);
    settled       = 1'b1;
    verdict_match = v;
    walk_phase    = PH_DONE;
  endtask

  task automatic advance_walk(input logic [7:0] b);
    logic [7:0] want;
    case (walk_phase)
      PH_LEN: begin
        if (b == 8'd0) begin
          settle(1'b0);
        end else begin
          remaining  = b;
          walk_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        remaining = remaining - 8'd1;
        if (b == regs.wanted_type) begin
          if (remaining < PREFIX_BYTES) begin
            settle(1'b0);
          end else begin
            pay_idx     = 3'd0;
            prefix_good = 1'b1;
            tag_seen    = 1'b0;
            flags_taken = 1'b0;
            pair_flag   = 1'b0;
            walk_phase  = PH_PAYLOAD;
          end
        end else begin
          walk_phase = (remaining == 8'd0) ? PH_LEN : PH_SKIP;
        end
      end
      PH_SKIP: begin
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) walk_phase = PH_LEN;
      end
      PH_PAYLOAD: begin
        remaining = remaining - 8'd1;
        if (pay_idx < PREFIX_BYTES) begin
          want    = regs.prefix_word[31 - 8 * pay_idx -: 8];
          pay_idx = pay_idx + 3'd1;
          if (b != want) prefix_good = 1'b0;
        end else if (!flags_taken) begin
          if (tag_seen) begin
            pair_flag   = ((b & regs.flag_mask) == regs.flag_mask);
            tag_seen    = 1'b0;
            flags_taken = 1'b1;
          end else if (b == regs.tag_value) begin
            tag_seen = 1'b1;
          end
        end
        // a prefix miss settles at once, otherwise the field end does
        if (!prefix_good || remaining == 8'd0) settle(prefix_good);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t due;
    if (!rst_n) begin
      regs.prefix_word = PREFIX_WORD_RST;
      regs.wanted_type = WANTED_TYPE_RST;
      regs.tag_value   = TAG_VALUE_RST;
      regs.flag_mask   = FLAG_MASK_RST;
      clear_walk();
      verdicts_due.delete();
    end else begin
      // a result can never belong to a byte taken on the same edge
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got match_found %0b pairing_on %0b",
                   $time, out_match_found, out_pairing_on);
          fail_count++;
        end else begin
          due = verdicts_due.pop_front();
          if (out_match_found !== due.match_found) begin
            $display("%0t: match_found expected %0b got %0b",
                     $time, due.match_found, out_match_found);
            fail_count++;
          end
          if (out_pairing_on !== due.pairing_on) begin
            $display("%0t: pairing_on expected %0b got %0b",
                     $time, due.pairing_on, out_pairing_on);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PREFIX_WORD: regs.prefix_word = cfg_data;
          REG_WANTED_TYPE: regs.wanted_type = cfg_data[7:0];
          REG_TAG_VALUE:   regs.tag_value   = cfg_data[7:0];
          REG_FLAG_MASK:   regs.flag_mask   = cfg_data[7:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        advance_walk(in_data_byte);
        if (in_is_last) begin
          due.match_found = settled && verdict_match;
          due.pairing_on  = settled && verdict_match && pair_flag;
          verdicts_due.push_back(due);
          clear_walk();
        end
      end
    end
    pending <= verdicts_due.size();
    errors  <= fail_count;
  end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives advertisements and register writes into the filter, gives the verdict.
`timescale 1ns / 1ps

module tb;
  import bamf_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic        out_match_found;
  logic        out_pairing_on;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int errors;
  int pending;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  bit hold_req = 1'b0;

  logic [31:0] cur_prefix;
  logic [7:0]  cur_type;
  logic [7:0]  cur_tag;
  logic [7:0]  cur_mask;
  logic [7:0]  adv_bytes[$];

  ble_adv_manufacturer_filter_top dut (.*);

  adv_filter_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ble_adv_manufacturer_filter_top test failed");
      $finish;
    end
  end

  // result side: random stalls in stretches, plus one long hold on request
  initial begin
    int  n;
    bit  busy_rx;
    bit  hold_done;
    busy_rx   = 1'b1;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 31) == 0) busy_rx = !busy_rx;
      n = busy_rx ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1 && !(hold_req && !hold_done)) @(posedge clk);
    end
  end

  task automatic add_plain_struct();
    int         len;
    logic [7:0] kind_code;
    len = ($urandom_range(0, 59) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
    kind_code = 8'($urandom_range(0, 255));
    if (kind_code == cur_type) kind_code = kind_code ^ 8'h01;
    adv_bytes.push_back(8'(len));
    adv_bytes.push_back(kind_code);
    repeat (len - 1) adv_bytes.push_back(8'($urandom));
  endtask

  task automatic add_wanted_struct();
    logic [7:0] body[$];
    int         body_len;
    int         spot;
    int         variant;
    variant  = $urandom_range(0, 9);
    body_len = (variant == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
    for (int i = 0; i < body_len; i++) body.push_back(8'($urandom));
    for (int i = 0; i < body_len && i < 4; i++) body[i] = cur_prefix[31 - 8 * i -: 8];
    if (variant == 1 && body_len >= 4)
      body[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    if (body_len > 4 && variant != 2) begin
      // tag may land on the last byte, leaving no flags byte
      spot = $urandom_range(4, body_len - 1);
      body[spot] = cur_tag;
      if (spot + 1 < body_len)
        body[spot + 1] = $urandom_range(0, 1) ? (8'($urandom) | cur_mask) : 8'($urandom);
    end
    adv_bytes.push_back(8'(body_len + 1));
    adv_bytes.push_back(cur_type);
    foreach (body[i]) adv_bytes.push_back(body[i]);
  endtask

  task automatic build_adv();
    int style;
    int cut;
    adv_bytes.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 12)) adv_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) add_plain_struct();
      if (style == 8) adv_bytes.push_back(8'h00);
      if (style != 9) add_wanted_struct();
      repeat ($urandom_range(0, 2)) add_plain_struct();
      if (style == 7) begin
        cut = $urandom_range(1, adv_bytes.size());
        while (adv_bytes.size() > cut) void'(adv_bytes.pop_back());
      end
    end
  endtask

  // valid stays high from one ad into the next when no gap is drawn
  task automatic send_adv(input bit no_gaps);
    int gap;
    bit burst;
    burst = no_gaps || ($urandom_range(0, 2) == 0);
    foreach (adv_bytes[i]) begin
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= adv_bytes[i];
      in_is_last   <= (i == adv_bytes.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] p, input logic [7:0] t, input logic [7:0] g,
                            input logic [7:0] m);
    repeat (4) @(posedge clk);
    write_reg(REG_PREFIX_WORD, p);
    write_reg(REG_WANTED_TYPE, {24'd0, t});
    write_reg(REG_TAG_VALUE, {24'd0, g});
    write_reg(REG_FLAG_MASK, {24'd0, m});
    cfg_valid <= 1'b0;
    cur_prefix = p;
    cur_type   = t;
    cur_tag    = g;
    cur_mask   = m;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'd0;
    in_is_last   <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_PREFIX_WORD;
    cfg_data     <= 32'd0;
    cur_prefix = PREFIX_WORD_RST;
    cur_type   = WANTED_TYPE_RST;
    cur_tag    = TAG_VALUE_RST;
    cur_mask   = FLAG_MASK_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    adv_bytes = '{8'h00};
    send_adv(1'b0);
    adv_bytes = '{8'h07, 8'hFF, 8'h2D, 8'h01, 8'h03, 8'h00, 8'h22, 8'h42};
    send_adv(1'b0);
    adv_bytes = '{8'h03, 8'hFF, 8'h2D};
    send_adv(1'b0);
    adv_bytes = '{8'h01, 8'h10};
    send_adv(1'b0);
    adv_bytes = '{8'h04, 8'hFF, 8'h2D, 8'h01, 8'h03};
    send_adv(1'b0);
    adv_bytes = '{8'h05, 8'hFF, 8'h2D, 8'h01, 8'h04, 8'h00};
    send_adv(1'b0);

    for (int phase_no = 0; phase_no < 7; phase_no++) begin
      if (phase_no > 0) begin
        wait_idle();
        case (phase_no)
          1: set_config(32'h0000_0000, 8'h00, 8'h00, 8'h00);
          2: set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
          5: set_config(PREFIX_WORD_RST, WANTED_TYPE_RST, TAG_VALUE_RST, FLAG_MASK_RST);
          default: set_config($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
        endcase
      end
      if (phase_no == 3) begin
        // receiver holds off while bytes keep coming back to back
        hold_req = 1'b1;
        repeat (8) begin
          build_adv();
          send_adv(1'b1);
        end
      end
      while (bytes_sent < 25 + (phase_no + 1) * 285) begin
        build_adv();
        send_adv(1'b0);
        if ($urandom_range(0, 30) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("ble_adv_manufacturer_filter_top test passed");
    else
      $display("ble_adv_manufacturer_filter_top test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bamf_pkg.sv
rtl/bamf_walker.sv
rtl/ble_adv_manufacturer_filter_top.sv
test/adv_filter_checker.sv
test/tb.sv
